### sv/trz_pkg.sv
// trz_pkg: shared constants, types and helpers of the triangle rasterizer
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package trz_pkg;

  localparam int SCREEN_SIDE = 64;
  localparam int SIDE_LOG2   = $clog2(SCREEN_SIDE);
  localparam int PIXELS      = SCREEN_SIDE * SCREEN_SIDE;
  localparam int ADDR_W      = 2 * SIDE_LOG2;
  localparam int POS_W       = SIDE_LOG2 + 1;
  // one screen unit is 32768 / SCREEN_SIDE in the biased coordinate
  localparam int STEP_LOG2   = 15 - SIDE_LOG2;
  localparam int COORD_W     = 16;
  localparam int U_W         = 17;
  localparam int DIFF_W      = 18;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int EDGE_W      = 40;
  localparam int COUNT_W     = 17;
  localparam int COLOR_W     = 24;
  localparam int DEPTH_W     = 8;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic step_x;
    logic step_row;
  } edge_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } edge_sts_t;

  // biased coordinate: v + 16384, screen position is u * SCREEN_SIDE / 32768
  function automatic logic signed [U_W-1:0] to_u(input logic [COORD_W-1:0] v);
    return $signed({v[COORD_W-1], v}) + $signed(U_W'(16384));
  endfunction

  // clamp to 0..SCREEN_SIDE, truncating
  function automatic logic [POS_W-1:0] bound_f(input logic signed [U_W-1:0] u);
    logic signed [U_W-1:0] t;
    t = u >>> STEP_LOG2;
    if (u < 0) return '0;
    if (t > $signed(U_W'(SCREEN_SIDE))) return POS_W'(SCREEN_SIDE);
    return t[POS_W-1:0];
  endfunction

endpackage

### sv/trz_frame_mem.sv
// trz_frame_mem: color and depth stores, one write and one registered read a cycle
// depends on trz_pkg
`timescale 1ns / 1ps

module trz_frame_mem (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [trz_pkg::ADDR_W-1:0]  wr_addr_i,
  input  logic [trz_pkg::COLOR_W-1:0] wr_color_i,
  input  logic [trz_pkg::DEPTH_W-1:0] wr_depth_i,
  input  logic [trz_pkg::ADDR_W-1:0]  rd_addr_i,
  output logic [trz_pkg::COLOR_W-1:0] rd_color_o,
  output logic [trz_pkg::DEPTH_W-1:0] rd_depth_o
);

  logic [trz_pkg::COLOR_W-1:0] color_mem [trz_pkg::PIXELS];
  logic [trz_pkg::DEPTH_W-1:0] depth_mem [trz_pkg::PIXELS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      color_mem[wr_addr_i] <= wr_color_i;
      depth_mem[wr_addr_i] <= wr_depth_i;
    end
    rd_color_o <= color_mem[rd_addr_i];
    rd_depth_o <= depth_mem[rd_addr_i];
  end

endmodule

### sv/trz_edge_walk.sv
// trz_edge_walk: edge function setup on one shared multiplier, then
// incremental stepping along the bounding box; depends on trz_pkg
`timescale 1ns / 1ps

module trz_edge_walk (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  trz_pkg::edge_ctl_t                    ctl_i,
  input  logic [2:0][trz_pkg::COORD_W-1:0]      vx_i,
  input  logic [2:0][trz_pkg::COORD_W-1:0]      vy_i,
  input  logic [trz_pkg::POS_W-1:0]             lo_x_i,
  input  logic [trz_pkg::POS_W-1:0]             lo_y_i,
  output trz_pkg::edge_sts_t                    sts_o
);

  localparam int LoPad = trz_pkg::DIFF_W - trz_pkg::POS_W - trz_pkg::STEP_LOG2;
  localparam int StPad = trz_pkg::EDGE_W - trz_pkg::DIFF_W - trz_pkg::STEP_LOG2;

  logic signed [trz_pkg::U_W-1:0]    ux [3];
  logic signed [trz_pkg::U_W-1:0]    uy [3];
  logic signed [trz_pkg::DIFF_W-1:0] dx [3];
  logic signed [trz_pkg::DIFF_W-1:0] dy [3];
  logic signed [trz_pkg::EDGE_W-1:0] sx [3];
  logic signed [trz_pkg::EDGE_W-1:0] sy [3];

  logic signed [trz_pkg::EDGE_W-1:0] e_q  [3];
  logic signed [trz_pkg::EDGE_W-1:0] er_q [3];

  logic [2:0] m_q, pm_q;
  logic       busy_q, pv_q;
  logic [1:0] idx, pidx;
  logic signed [trz_pkg::DIFF_W-1:0] lsx, lsy, op_a, op_b;
  logic signed [trz_pkg::PROD_W-1:0] prod_q;
  logic signed [trz_pkg::EDGE_W-1:0] prod_ext, e_sub;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ux[i] = trz_pkg::to_u(vx_i[i]);
      uy[i] = trz_pkg::to_u(vy_i[i]);
    end
    for (int i = 0; i < 3; i++) begin
      dx[i] = $signed({ux[(i+1)%3][trz_pkg::U_W-1], ux[(i+1)%3]})
            - $signed({ux[i][trz_pkg::U_W-1], ux[i]});
      dy[i] = $signed({uy[(i+1)%3][trz_pkg::U_W-1], uy[(i+1)%3]})
            - $signed({uy[i][trz_pkg::U_W-1], uy[i]});
      sx[i] = $signed({{StPad{dy[i][trz_pkg::DIFF_W-1]}}, dy[i],
                       {trz_pkg::STEP_LOG2{1'b0}}});
      sy[i] = $signed({{StPad{dx[i][trz_pkg::DIFF_W-1]}}, dx[i],
                       {trz_pkg::STEP_LOG2{1'b0}}});
    end
  end

  // operand select: even step dx*(py-ay), odd step dy*(px-ax)
  assign idx  = (m_q[2:1] == 2'd3) ? 2'd0 : m_q[2:1];
  assign pidx = (pm_q[2:1] == 2'd3) ? 2'd0 : pm_q[2:1];
  assign lsx  = $signed({{LoPad{1'b0}}, lo_x_i, {trz_pkg::STEP_LOG2{1'b0}}});
  assign lsy  = $signed({{LoPad{1'b0}}, lo_y_i, {trz_pkg::STEP_LOG2{1'b0}}});
  assign op_a = m_q[0] ? dy[idx] : dx[idx];
  assign op_b = m_q[0] ? (lsx - $signed({ux[idx][trz_pkg::U_W-1], ux[idx]}))
                       : (lsy - $signed({uy[idx][trz_pkg::U_W-1], uy[idx]}));

  assign prod_ext = $signed({{(trz_pkg::EDGE_W-trz_pkg::PROD_W){prod_q[trz_pkg::PROD_W-1]}},
                             prod_q});
  assign e_sub    = e_q[pidx] - prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q    <= '0;
      pm_q   <= '0;
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
    end else if (ctl_i.start) begin
      m_q    <= '0;
      busy_q <= 1'b1;
      pv_q   <= 1'b0;
    end else if (busy_q) begin
      if (m_q != 3'd6) begin
        pm_q <= m_q;
        pv_q <= 1'b1;
        m_q  <= m_q + 3'd1;
      end else begin
        pv_q   <= 1'b0;
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && m_q != 3'd6) begin
      prod_q <= op_a * op_b;
    end
    if (pv_q) begin
      if (!pm_q[0]) begin
        e_q[pidx] <= prod_ext;
      end else begin
        e_q[pidx]  <= e_sub;
        er_q[pidx] <= e_sub;
      end
    end else if (ctl_i.step_row) begin
      for (int i = 0; i < 3; i++) begin
        er_q[i] <= er_q[i] + sy[i];
        e_q[i]  <= er_q[i] + sy[i];
      end
    end else if (ctl_i.step_x) begin
      for (int i = 0; i < 3; i++) begin
        e_q[i] <= e_q[i] - sx[i];
      end
    end
  end

  logic p0, p1, p2;
  assign p0 = e_q[0] > 0;
  assign p1 = e_q[1] > 0;
  assign p2 = e_q[2] > 0;

  assign sts_o.done = pv_q && (pm_q == 3'd5);
  assign sts_o.hit  = (p0 == p1) && (p0 == p2);

endmodule

### sv/triangle_rasterizer_zbuffer_top.sv
// triangle_rasterizer_zbuffer_top: sequencer, vertex registers and depth test
// depends on trz_pkg, trz_edge_walk, trz_frame_mem
//
//  channel | handshake                   | payload
//  in      | in_valid_i / in_stall_o      | action, vertex_slot, coord xyz, rgb, read pos
//  out     | out_valid_o / out_stall_i    | pixel rgb, pixel_depth, pixels_written
//  cfg     | cfg_we_i                     | cfg_wdata_i (blend_or)
//
// load takes the vertex; read returns the registered store word; clear sweeps every pixel to zero
// draw: setup on the shared multiplier, then a walk of the box, one pixel per cycle
// (an empty box skips the walk)
// after reset the stores are swept to zero and input is stalled meanwhile;
// one item is in work at a time and the next is taken once its result beat
// has left the output register
`timescale 1ns / 1ps

module triangle_rasterizer_zbuffer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [1:0]                    vertex_slot_i,
  input  logic [15:0]                   coord_x_i,
  input  logic [15:0]                   coord_y_i,
  input  logic [15:0]                   coord_z_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic [7:0]                    read_column_i,
  input  logic [7:0]                    read_row_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    pixel_red_o,
  output logic [7:0]                    pixel_green_o,
  output logic [7:0]                    pixel_blue_o,
  output logic [7:0]                    pixel_depth_o,
  output logic [16:0]                   pixels_written_o
);

  localparam int SL = trz_pkg::SIDE_LOG2;
  localparam int PW = trz_pkg::POS_W;

  trz_pkg::state_e state_q, state_d;
  trz_pkg::edge_ctl_t ctl;
  trz_pkg::edge_sts_t sts;

  logic blend_q;
  logic [2:0][15:0] vx_q, vy_q, vz_q;

  logic accept;
  logic [trz_pkg::ADDR_W-1:0] sweep_q;
  logic sweep_en, sweep_last;

  logic [PW-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, x_q, y_q;
  logic [7:0] depth_q;
  logic [trz_pkg::COLOR_W-1:0] color_q;
  logic [trz_pkg::COUNT_W-1:0] count_q;
  logic box_empty, last_x, last_y;

  logic p_valid_q, p_keep_q;
  logic [trz_pkg::ADDR_W-1:0] p_addr_q;
  logic commit;
  logic rd_in_q;

  logic wr_en;
  logic [trz_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [trz_pkg::COLOR_W-1:0] wr_color, rd_color;
  logic [7:0] wr_depth, rd_depth;

  logic out_valid_q;
  logic [7:0] pr_q, pg_q, pb_q, pd_q;
  logic [trz_pkg::COUNT_W-1:0] pw_q;

  // bounds and depth of the loaded triangle
  logic signed [trz_pkg::U_W-1:0] ux [3];
  logic signed [trz_pkg::U_W-1:0] uy [3];
  logic signed [trz_pkg::U_W-1:0] uz [3];
  logic signed [trz_pkg::U_W-1:0] min_x, max_x, min_y, max_y, max_z, zq;
  logic [7:0] depth_new;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ux[i] = trz_pkg::to_u(vx_q[i]);
      uy[i] = trz_pkg::to_u(vy_q[i]);
      uz[i] = trz_pkg::to_u(vz_q[i]);
    end
    min_x = ux[0]; max_x = ux[0];
    min_y = uy[0]; max_y = uy[0];
    max_z = uz[0];
    for (int i = 1; i < 3; i++) begin
      if (ux[i] < min_x) min_x = ux[i];
      if (ux[i] > max_x) max_x = ux[i];
      if (uy[i] < min_y) min_y = uy[i];
      if (uy[i] > max_y) max_y = uy[i];
      if (uz[i] > max_z) max_z = uz[i];
    end
    zq = max_z >>> trz_pkg::STEP_LOG2;
    if (max_z < 0) depth_new = 8'd0;
    else if (zq > $signed(trz_pkg::U_W'(255))) depth_new = 8'd255;
    else depth_new = zq[7:0];
  end

  assign in_stall_o = (state_q != trz_pkg::ST_IDLE) || out_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign sweep_last = (sweep_q == trz_pkg::ADDR_W'(trz_pkg::PIXELS - 1));
  assign box_empty  = (lo_x_q >= hi_x_q) || (lo_y_q >= hi_y_q);
  assign last_x     = (x_q + PW'(1)) == hi_x_q;
  assign last_y     = (y_q + PW'(1)) == hi_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= trz_pkg::ST_INIT;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d  = state_q;
    ctl      = '0;
    sweep_en = 1'b0;
    case (state_q)
      trz_pkg::ST_INIT: begin
        sweep_en = 1'b1;
        if (sweep_last) state_d = trz_pkg::ST_IDLE;
      end
      trz_pkg::ST_IDLE: begin
        if (accept) begin
          case (trz_pkg::action_e'(action_i))
            trz_pkg::ACT_DRAW: begin
              ctl.start = 1'b1;
              state_d   = trz_pkg::ST_SETUP;
            end
            trz_pkg::ACT_CLEAR: state_d = trz_pkg::ST_CLEAR;
            trz_pkg::ACT_READ:  state_d = trz_pkg::ST_READ;
            default:            state_d = trz_pkg::ST_IDLE;
          endcase
        end
      end
      trz_pkg::ST_CLEAR: begin
        sweep_en = 1'b1;
        if (sweep_last) state_d = trz_pkg::ST_FIN;
      end
      trz_pkg::ST_SETUP: begin
        if (sts.done) state_d = box_empty ? trz_pkg::ST_FIN : trz_pkg::ST_WALK;
      end
      trz_pkg::ST_WALK: begin
        if (!last_x) ctl.step_x = 1'b1;
        else if (!last_y) ctl.step_row = 1'b1;
        else state_d = trz_pkg::ST_DRAIN;
      end
      trz_pkg::ST_DRAIN: state_d = trz_pkg::ST_FIN;
      trz_pkg::ST_READ:  state_d = trz_pkg::ST_IDLE;
      trz_pkg::ST_FIN:   state_d = trz_pkg::ST_IDLE;
      default:           state_d = trz_pkg::ST_IDLE;
    endcase
  end

  trz_edge_walk u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .vx_i   (vx_q),
    .vy_i   (vy_q),
    .lo_x_i (lo_x_q),
    .lo_y_i (lo_y_q),
    .sts_o  (sts)
  );

  // depth test in the cycle after the walk visits the pixel, on the registered read
  assign commit = p_valid_q && p_keep_q && (depth_q >= rd_depth);

  always_comb begin
    wr_en    = sweep_en || commit;
    wr_addr  = sweep_en ? sweep_q : p_addr_q;
    wr_color = sweep_en ? '0 : (blend_q ? (rd_color | color_q) : color_q);
    wr_depth = sweep_en ? '0 : depth_q;
    if (state_q == trz_pkg::ST_WALK) rd_addr = {y_q[SL-1:0], x_q[SL-1:0]};
    else                              rd_addr = {read_row_i[SL-1:0], read_column_i[SL-1:0]};
  end

  trz_frame_mem u_mem (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_color_i (wr_color),
    .wr_depth_i (wr_depth),
    .rd_addr_i  (rd_addr),
    .rd_color_o (rd_color),
    .rd_depth_o (rd_depth)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q     <= 1'b0;
      vx_q        <= '0;
      vy_q        <= '0;
      vz_q        <= '0;
      sweep_q     <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) blend_q <= cfg_wdata_i;
      if (accept && trz_pkg::action_e'(action_i) == trz_pkg::ACT_LOAD) begin
        case (vertex_slot_i)
          2'd0: begin vx_q[0] <= coord_x_i; vy_q[0] <= coord_y_i; vz_q[0] <= coord_z_i; end
          2'd1: begin vx_q[1] <= coord_x_i; vy_q[1] <= coord_y_i; vz_q[1] <= coord_z_i; end
          2'd2: begin vx_q[2] <= coord_x_i; vy_q[2] <= coord_y_i; vz_q[2] <= coord_z_i; end
          default: ;
        endcase
      end
      if (sweep_en) sweep_q <= sweep_last ? '0 : sweep_q + trz_pkg::ADDR_W'(1);
      p_valid_q <= (state_q == trz_pkg::ST_WALK);
      if (accept) count_q <= '0;
      else if (commit) count_q <= count_q + trz_pkg::COUNT_W'(1);
      if ((accept && trz_pkg::action_e'(action_i) == trz_pkg::ACT_LOAD)
          || state_q == trz_pkg::ST_FIN || state_q == trz_pkg::ST_READ) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      color_q <= {red_i, green_i, blue_i};
      depth_q <= depth_new;
      lo_x_q  <= trz_pkg::bound_f(min_x);
      hi_x_q  <= trz_pkg::bound_f(max_x);
      lo_y_q  <= trz_pkg::bound_f(min_y);
      hi_y_q  <= trz_pkg::bound_f(max_y);
      rd_in_q <= ({1'b0, read_column_i} < 9'(trz_pkg::SCREEN_SIDE))
              && ({1'b0, read_row_i} < 9'(trz_pkg::SCREEN_SIDE));
    end
    if (state_q == trz_pkg::ST_SETUP) begin
      x_q <= lo_x_q;
      y_q <= lo_y_q;
    end else if (ctl.step_x) begin
      x_q <= x_q + PW'(1);
    end else if (ctl.step_row) begin
      x_q <= lo_x_q;
      y_q <= y_q + PW'(1);
    end
    p_addr_q <= {y_q[SL-1:0], x_q[SL-1:0]};
    p_keep_q <= sts.hit;
    if (accept || state_q == trz_pkg::ST_FIN) begin
      pr_q <= '0;
      pg_q <= '0;
      pb_q <= '0;
      pd_q <= '0;
      pw_q <= accept ? '0 : count_q;
    end else if (state_q == trz_pkg::ST_READ) begin
      pr_q <= rd_in_q ? rd_color[23:16] : 8'd0;
      pg_q <= rd_in_q ? rd_color[15:8]  : 8'd0;
      pb_q <= rd_in_q ? rd_color[7:0]   : 8'd0;
      pd_q <= rd_in_q ? rd_depth        : 8'd0;
      pw_q <= '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_red_o      = pr_q;
  assign pixel_green_o    = pg_q;
  assign pixel_blue_o     = pb_q;
  assign pixel_depth_o    = pd_q;
  assign pixels_written_o = pw_q;

endmodule

### sv/trz_checker.sv
// trz_checker: port-level assertions for the rasterizer top
// bound to triangle_rasterizer_zbuffer_top, no other dependencies
`timescale 1ns / 1ps

module trz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  pixel_red_o,
  input logic [7:0]  pixel_green_o,
  input logic [7:0]  pixel_blue_o,
  input logic [7:0]  pixel_depth_o,
  input logic [16:0] pixels_written_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixels_written_o)
      && $stable(pixel_depth_o))
    else $error("stalled result beat changed");

  // one item at a time: busy right after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // no new item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // a draw count and read pixel data never come in the same beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixels_written_o != 17'd0 |->
      pixel_red_o == 8'd0 && pixel_green_o == 8'd0 && pixel_blue_o == 8'd0
      && pixel_depth_o == 8'd0)
    else $error("draw result carries pixel data");

  // a draw can write no more than the whole screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixels_written_o <= 17'(trz_pkg::PIXELS))
    else $error("pixel count beyond screen size");

endmodule

bind triangle_rasterizer_zbuffer_top trz_checker u_trz_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .pixel_red_o      (pixel_red_o),
  .pixel_green_o    (pixel_green_o),
  .pixel_blue_o     (pixel_blue_o),
  .pixel_depth_o    (pixel_depth_o),
  .pixels_written_o (pixels_written_o)
);

### sim/trz_scoreboard.sv
// trz_scoreboard: watches the rasterizer channels, mirrors its frame and
// depth stores, predicts each result beat and compares it; uses trz_pkg
`timescale 1ns / 1ps

module trz_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [1:0]  vertex_slot_i,
  input  logic [15:0] coord_x_i,
  input  logic [15:0] coord_y_i,
  input  logic [15:0] coord_z_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  read_column_i,
  input  logic [7:0]  read_row_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  pixel_red_i,
  input  logic [7:0]  pixel_green_i,
  input  logic [7:0]  pixel_blue_i,
  input  logic [7:0]  pixel_depth_i,
  input  logic [16:0] pixels_written_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          draws_o,
  output int          pixels_total_o
);

  typedef struct {
    logic [7:0]  r, g, b, d;
    logic [16:0] n;
  } pixel_beat_t;

  logic [trz_pkg::COLOR_W-1:0] frame_q [trz_pkg::PIXELS];
  logic [trz_pkg::DEPTH_W-1:0] zbuf_q  [trz_pkg::PIXELS];
  logic signed [15:0] vtx_q   [3][3];
  logic               blend_q;
  pixel_beat_t        expected_q[$];

  function automatic longint scr(input logic signed [15:0] v);
    return longint'(trz_pkg::SCREEN_SIDE) * (longint'(v) + 16384);
  endfunction

  function automatic longint clip(input longint p);
    longint b;
    if (p < 0) return 0;
    b = p / 32768;
    return (b > trz_pkg::SCREEN_SIDE) ? trz_pkg::SCREEN_SIDE : b;
  endfunction

  function automatic bit edge_pos(input longint ax, ay, bx, by, px, py);
    return (bx - ax) * (py - ay) - (by - ay) * (px - ax) > 0;
  endfunction

  function automatic logic [16:0] raster(input logic [trz_pkg::COLOR_W-1:0] rgb);
    longint sx[3], sy[3];
    longint lx, hx, ly, hy, zm, zq, px, py;
    bit e0, e1, e2;
    int idx, cnt;
    logic [7:0] dep;
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      sx[i] = scr(vtx_q[i][0]);
      sy[i] = scr(vtx_q[i][1]);
    end
    lx = sx[0]; hx = sx[0]; ly = sy[0]; hy = sy[0]; zm = scr(vtx_q[0][2]);
    for (int i = 1; i < 3; i++) begin
      if (sx[i] < lx) lx = sx[i];
      if (sx[i] > hx) hx = sx[i];
      if (sy[i] < ly) ly = sy[i];
      if (sy[i] > hy) hy = sy[i];
      if (scr(vtx_q[i][2]) > zm) zm = scr(vtx_q[i][2]);
    end
    zq = (zm < 0) ? 0 : zm / 32768;
    dep = (zq > 255) ? 8'd255 : 8'(zq);
    lx = clip(lx); hx = clip(hx); ly = clip(ly); hy = clip(hy);
    for (longint y = ly; y < hy; y++) begin
      for (longint x = lx; x < hx; x++) begin
        px = x * 32768;
        py = y * 32768;
        e0 = edge_pos(sx[0], sy[0], sx[1], sy[1], px, py);
        e1 = edge_pos(sx[1], sy[1], sx[2], sy[2], px, py);
        e2 = edge_pos(sx[2], sy[2], sx[0], sy[0], px, py);
        if (e0 == e1 && e0 == e2) begin
          idx = int'(y) * trz_pkg::SCREEN_SIDE + int'(x);
          if (dep >= zbuf_q[idx]) begin
            frame_q[idx] = blend_q ? (frame_q[idx] | rgb) : rgb;
            zbuf_q[idx]  = dep;
            cnt++;
          end
        end
      end
    end
    return 17'(cnt);
  endfunction

  task automatic check_field(input string name, input logic [16:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_beat_t e;
    int idx;
    if (!rst_ni) begin
      foreach (frame_q[i]) begin
        frame_q[i] = '0;
        zbuf_q[i]  = '0;
      end
      foreach (vtx_q[i, j]) vtx_q[i][j] = '0;
      blend_q = 1'b0;
      expected_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      draws_o        = 0;
      pixels_total_o = 0;
    end else begin
      if (cfg_we_i) blend_q = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          check_field("pixel_red", e.r, pixel_red_i);
          check_field("pixel_green", e.g, pixel_green_i);
          check_field("pixel_blue", e.b, pixel_blue_i);
          check_field("pixel_depth", e.d, pixel_depth_i);
          check_field("pixels_written", e.n, pixels_written_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        e = '{8'd0, 8'd0, 8'd0, 8'd0, 17'd0};
        case (trz_pkg::action_e'(action_i))
          trz_pkg::ACT_LOAD: begin
            if (vertex_slot_i < 3) begin
              vtx_q[vertex_slot_i][0] = coord_x_i;
              vtx_q[vertex_slot_i][1] = coord_y_i;
              vtx_q[vertex_slot_i][2] = coord_z_i;
            end
          end
          trz_pkg::ACT_DRAW: begin
            e.n = raster({red_i, green_i, blue_i});
            draws_o++;
            pixels_total_o += int'(e.n);
          end
          trz_pkg::ACT_CLEAR: begin
            foreach (frame_q[i]) begin
              frame_q[i] = '0;
              zbuf_q[i]  = '0;
            end
          end
          default: begin
            if (read_column_i < trz_pkg::SCREEN_SIDE
                && read_row_i < trz_pkg::SCREEN_SIDE) begin
              idx = int'(read_row_i) * trz_pkg::SCREEN_SIDE + int'(read_column_i);
              {e.r, e.g, e.b} = frame_q[idx];
              e.d = zbuf_q[idx];
            end
          end
        endcase
        expected_q.push_back(e);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### sim/tb_triangle_rasterizer_zbuffer_top.sv
// tb_triangle_rasterizer_zbuffer_top: stimulus, handshake pacing and verdict
// depends on trz_pkg, triangle_rasterizer_zbuffer_top and trz_scoreboard
`timescale 1ns / 1ps

module tb_triangle_rasterizer_zbuffer_top;

  localparam int WATCHDOG = 60000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [1:0]  vertex_slot_i = '0;
  logic [15:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [7:0]  red_i = '0, green_i = '0, blue_i = '0;
  logic [7:0]  read_column_i = '0, read_row_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  pixel_red_o, pixel_green_o, pixel_blue_o, pixel_depth_o;
  logic [16:0] pixels_written_o;
  int          fail_count, pending, draws, pixels_total;
  int          items_sent = 0, beats_seen = 0, idle_cycles = 0;
  bit          stim_done = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  triangle_rasterizer_zbuffer_top u_dut (.*);

  trz_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .vertex_slot_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .red_i, .green_i, .blue_i,
    .read_column_i, .read_row_i,
    .out_valid_i(out_valid_o), .out_stall_i, .pixel_red_i(pixel_red_o),
    .pixel_green_i(pixel_green_o), .pixel_blue_i(pixel_blue_o),
    .pixel_depth_i(pixel_depth_o), .pixels_written_i(pixels_written_o),
    .fail_count_o(fail_count), .pending_o(pending), .draws_o(draws),
    .pixels_total_o(pixels_total)
  );

  // one input beat: random gap, then hold until taken
  task automatic send(input trz_pkg::action_e act, input logic [1:0] slot,
                      input logic [15:0] x, y, z, input logic [23:0] rgb,
                      input logic [7:0] col, row);
    int gap;
    gap = (items_sent % 40 < 10) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    vertex_slot_i <= slot;
    coord_x_i     <= x;
    coord_y_i     <= y;
    coord_z_i     <= z;
    {red_i, green_i, blue_i} <= rgb;
    read_column_i <= col;
    read_row_i    <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic load(input logic [1:0] slot, input logic [15:0] x, y, z);
    send(trz_pkg::ACT_LOAD, slot, x, y, z, 24'h0, 8'h0, 8'h0);
  endtask

  task automatic tri3(input logic [15:0] x0, y0, x1, y1, x2, y2, z,
                      input logic [23:0] rgb);
    load(2'd0, x0, y0, z);
    load(2'd1, x1, y1, 16'h0);
    load(2'd2, x2, y2, 16'h0);
    send(trz_pkg::ACT_DRAW, 2'd0, 16'h0, 16'h0, 16'h0, rgb, 8'h0, 8'h0);
  endtask

  task automatic readpx(input logic [7:0] col, row);
    send(trz_pkg::ACT_READ, 2'd0, 16'h0, 16'h0, 16'h0, 24'h0, col, row);
  endtask

  // quiesce, then write the blend register
  task automatic set_blend(input logic v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [15:0] rnd_coord();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  function automatic logic [7:0] rnd_pos();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(0, trz_pkg::SCREEN_SIDE - 1));
  endfunction

  task automatic random_phase(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 4) != 0) begin
        // well-formed: three vertices, a draw, a few reads
        tri3(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
             rnd_coord(), rnd_coord(), 24'($urandom));
        repeat ($urandom_range(1, 3)) readpx(rnd_pos(), rnd_pos());
      end else begin
        case ($urandom_range(0, 9))
          0: send(trz_pkg::ACT_CLEAR, 2'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 24'($urandom), 8'($urandom), 8'($urandom));
          1, 2: send(trz_pkg::ACT_DRAW, 2'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 24'($urandom), 8'($urandom), 8'($urandom));
          3, 4, 5: load(2'($urandom), rnd_coord(), rnd_coord(), 16'($urandom));
          default: readpx(8'($urandom), 8'($urandom));
        endcase
      end
    end
  endtask

  // receiver pacing, with one long hold-off to back the block up
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = (beats_seen % 50 < 12) ? 0 : $urandom_range(0, 19);
      if (beats_seen == 30) n = 600;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      beats_seen++;
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired, %0d results pending", pending);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_blend(1'b0);

    // directed: extremes, slot three, degenerate and off-screen triangles
    load(2'd0, 16'h8000, 16'h8000, 16'h7fff);
    load(2'd1, 16'h7fff, 16'h8000, 16'h8000);
    load(2'd2, 16'h8000, 16'h7fff, 16'h0000);
    send(trz_pkg::ACT_DRAW, 2'd0, 16'h0, 16'h0, 16'h0, 24'hffffff, 8'h0, 8'h0);
    readpx(8'd0, 8'd0);
    readpx(8'd63, 8'd63);
    readpx(8'd64, 8'd0);
    readpx(8'd255, 8'd255);
    load(2'd3, 16'h1234, 16'h4321, 16'h7fff);
    tri3(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
         16'h0000, 24'h123456);
    tri3(16'hc000, 16'hc000, 16'h0000, 16'h0000, 16'h3fff, 16'h3fff,
         16'h4000, 24'h00ff00);
    tri3(16'h6000, 16'h6000, 16'h7000, 16'h6000, 16'h6000, 16'h7000,
         16'h7fff, 24'h0000ff);
    tri3(16'h3fff, 16'hc000, 16'hc000, 16'hc000, 16'h0000, 16'h3fff,
         16'h8000, 24'haa5500);
    readpx(8'd32, 8'd20);
    send(trz_pkg::ACT_CLEAR, 2'd0, 16'h0, 16'h0, 16'h0, 24'h0, 8'h0, 8'h0);
    readpx(8'd32, 8'd20);

    set_blend(1'b1);
    tri3(16'hc000, 16'hc000, 16'h3fff, 16'hc000, 16'hc000, 16'h3fff,
         16'h2000, 24'h0f0f0f);
    random_phase(54);
    set_blend(1'b0);
    random_phase(54);

    in_valid_i <= 1'b0;
    stim_done = 1'b1;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("%0d items sent, %0d draws wrote %0d pixels, %0d results checked",
             items_sent, draws, pixels_total, beats_seen);
    $display("blend modes overwrite and or, with clears, off-screen reads and a long output hold-off");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
